FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the framer RTL.
// Each macro expands to one labeled concurrent assertion on the block clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define DPSF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define DPSF_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/dpsf_pkg.sv
// Types, opcode constants and the payload length table of the packet framer.
// No dependencies; imported by dpsf_core and dma_packet_stream_framer.
`timescale 1ns / 1ps
`default_nettype none

package dpsf_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned OP_W   = 8;
   localparam int unsigned ID_W   = 4;
   localparam int unsigned LEN_W  = 4;
   localparam int unsigned TDATA_W = 184;

   // opcodes
   localparam logic [OP_W-1:0] OP_NOP         = 8'd0;
   localparam logic [OP_W-1:0] OP_COPY        = 8'd1;
   localparam logic [OP_W-1:0] OP_WRITE       = 8'd2;
   localparam logic [OP_W-1:0] OP_INDIRECT    = 8'd4;
   localparam logic [OP_W-1:0] OP_SEMAPHORE   = 8'd5;
   localparam logic [OP_W-1:0] OP_FENCE       = 8'd6;
   localparam logic [OP_W-1:0] OP_TRAP        = 8'd7;
   localparam logic [OP_W-1:0] OP_POLL_REGMEM = 8'd8;
   localparam logic [OP_W-1:0] OP_POLL_REG    = 8'd9;
   localparam logic [OP_W-1:0] OP_COND_EXE    = 8'd10;
   localparam logic [OP_W-1:0] OP_ATOMIC      = 8'd11;
   localparam logic [OP_W-1:0] OP_CONST_FILL  = 8'd12;
   localparam logic [OP_W-1:0] OP_TIMESTAMP   = 8'd13;
   localparam logic [OP_W-1:0] OP_SRBM_WRITE  = 8'd14;
   localparam logic [OP_W-1:0] OP_PRE_EXE     = 8'd15;

   // sub-opcodes
   localparam logic [OP_W-1:0] SUB_COPY_LINEAR = 8'd0;
   localparam logic [OP_W-1:0] SUB_COPY_TILED  = 8'd1;
   localparam logic [OP_W-1:0] SUB_COPY_L2T    = 8'd3;
   localparam logic [OP_W-1:0] SUB_COPY_T2T    = 8'd4;
   localparam logic [OP_W-1:0] SUB_COPY_SOA    = 8'd5;
   localparam logic [OP_W-1:0] SUB_COPY_DIRTY  = 8'd6;
   localparam logic [OP_W-1:0] SUB_WRITE_LINEAR = 8'd0;
   localparam logic [OP_W-1:0] SUB_WRITE_TILED  = 8'd1;
   localparam logic [OP_W-1:0] SUB_TIMESTAMP_MAX = 8'd2;

   // header bit that extends a linear copy by two words
   localparam int unsigned COPY_EXT_BIT = 27;
   localparam int unsigned ID_LSB       = 16;

   // linear write: payload position of the count word, and largest count that does not wrap
   localparam logic [WORD_W-1:0] WRITE_COUNT_POS = 32'd3;
   localparam logic [WORD_W-1:0] WRITE_COUNT_MAX = 32'hFFFF_FFFC;

   // payload positions of the indirect buffer fields
   localparam logic [WORD_W-1:0] IB_ADDR_LO_POS = 32'd1;
   localparam logic [WORD_W-1:0] IB_ADDR_HI_POS = 32'd2;
   localparam logic [WORD_W-1:0] IB_SIZE_POS    = 32'd3;

   typedef struct packed {
      logic [WORD_W-1:0]   word_out;
      logic                is_header;
      logic [OP_W-1:0]     pkt_opcode;
      logic [OP_W-1:0]     pkt_sub_opcode;
      logic [WORD_W-1:0]   word_position;
      logic                packet_end;
      logic                truncated;
      logic                ib_valid;
      logic [ID_W-1:0]     ib_id;
      logic                ib_hub;
      logic [2*WORD_W-1:0] ib_address;
      logic [WORD_W-1:0]   ib_length;
   } dpsf_result_type;

   // payload words that follow a header; a provisional 3 for the linear write
   function automatic logic [LEN_W-1:0] payload_len(input logic [OP_W-1:0] op,
                                                    input logic [OP_W-1:0] sub,
                                                    input logic ext);
      logic [LEN_W-1:0] len;
      len = '0;
      unique case (op)
         OP_COPY: begin
            unique case (sub)
               SUB_COPY_LINEAR: len = ext ? 4'd8 : 4'd6;
               SUB_COPY_TILED:  len = 4'd11;
               SUB_COPY_L2T:    len = 4'd7;
               SUB_COPY_T2T:    len = 4'd12;
               SUB_COPY_SOA:    len = 4'd13;
               SUB_COPY_DIRTY:  len = 4'd14;
               default:         len = 4'd0;
            endcase
         end
         OP_WRITE: begin
            unique case (sub)
               SUB_WRITE_LINEAR: len = 4'd3;
               SUB_WRITE_TILED:  len = 4'd9;
               default:          len = 4'd0;
            endcase
         end
         OP_INDIRECT:    len = 4'd5;
         OP_SEMAPHORE:   len = 4'd3;
         OP_FENCE:       len = 4'd1;
         OP_TRAP:        len = 4'd2;
         OP_POLL_REGMEM: len = (sub != '0) ? 4'd3 : 4'd5;
         OP_POLL_REG:    len = 4'd4;
         OP_COND_EXE:    len = 4'd7;
         OP_ATOMIC:      len = 4'd4;
         OP_CONST_FILL:  len = 4'd9;
         OP_TIMESTAMP:   len = (sub <= SUB_TIMESTAMP_MAX) ? 4'd2 : 4'd0;
         OP_SRBM_WRITE:  len = 4'd2;
         OP_PRE_EXE:     len = 4'd1;
         default:        len = 4'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dpsf_core.sv
// Framing state and per-word tagging logic of the packet framer.
// Depends on dpsf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dpsf_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic                      csr_wr_data,
   input  wire logic                      step,
   input  wire logic [31:0]               word,
   input  wire logic                      last,
   output dpsf_pkg::dpsf_result_type      res
);
   import dpsf_pkg::*;

   logic                hub_mode_ff, hub_mode_in;
   logic                active_ff, active_in;
   logic                len_pending_ff, len_pending_in;
   logic [WORD_W-1:0]   words_left_ff, words_left_in;
   logic [OP_W-1:0]     opcode_ff, opcode_in;
   logic [OP_W-1:0]     sub_opcode_ff, sub_opcode_in;
   logic [WORD_W-1:0]   position_ff, position_in;
   logic [WORD_W-1:0]   addr_lo_ff, addr_lo_in;
   logic [WORD_W-1:0]   addr_hi_ff, addr_hi_in;
   logic [WORD_W-1:0]   size_ff, size_in;
   logic [ID_W-1:0]     id_ff, id_in;

   logic                header;
   logic                pending;
   logic [WORD_W-1:0]   remaining;
   logic                pkt_end;

   assign hub_mode_in = csr_wr_en ? csr_wr_data : hub_mode_ff;

   always_comb begin
      header        = !active_ff;
      opcode_in     = opcode_ff;
      sub_opcode_in = sub_opcode_ff;
      position_in   = position_ff;
      pending       = len_pending_ff;
      addr_lo_in    = addr_lo_ff;
      addr_hi_in    = addr_hi_ff;
      size_in       = size_ff;
      id_in         = id_ff;
      remaining     = '0;
      if (header) begin
         opcode_in     = word[OP_W-1:0];
         sub_opcode_in = word[2*OP_W-1:OP_W];
         position_in   = '0;
         remaining     = WORD_W'(payload_len(word[OP_W-1:0], word[2*OP_W-1:OP_W],
                                             word[COPY_EXT_BIT]));
         pending       = (word[OP_W-1:0] == OP_WRITE) &&
                         (word[2*OP_W-1:OP_W] == SUB_WRITE_LINEAR);
         if (word[OP_W-1:0] == OP_INDIRECT) begin
            id_in = word[ID_LSB +: ID_W];
         end
      end else begin
         // saturate the position at all ones
         if (position_ff != '1) begin
            position_in = position_ff + WORD_W'(1);
         end
         remaining = words_left_ff - WORD_W'(1);
         // the count word fixes the linear write length; a wrapped length ends here
         if (len_pending_ff && (position_in == WRITE_COUNT_POS)) begin
            remaining = (word > WRITE_COUNT_MAX) ? '0 : word;
            pending   = 1'b0;
         end
         if (opcode_ff == OP_INDIRECT) begin
            if (position_in == IB_ADDR_LO_POS) addr_lo_in = word;
            if (position_in == IB_ADDR_HI_POS) addr_hi_in = word;
            if (position_in == IB_SIZE_POS)    size_in    = word;
         end
      end
      pkt_end = (remaining == '0);
   end

   always_comb begin
      if (pkt_end || last) begin
         active_in      = 1'b0;
         len_pending_in = 1'b0;
         words_left_in  = '0;
      end else begin
         active_in      = 1'b1;
         len_pending_in = pending;
         words_left_in  = remaining;
      end
   end

   always_comb begin
      res                = '0;
      res.word_out       = word;
      res.is_header      = header;
      res.pkt_opcode     = opcode_in;
      res.pkt_sub_opcode = sub_opcode_in;
      res.word_position  = position_in;
      res.packet_end     = pkt_end;
      res.truncated      = !pkt_end && last;
      if (pkt_end && (opcode_in == OP_INDIRECT)) begin
         res.ib_valid   = 1'b1;
         res.ib_id      = id_in;
         res.ib_hub     = hub_mode_ff;
         res.ib_address = {addr_hi_in, addr_lo_in};
         res.ib_length  = size_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hub_mode_ff    <= 1'b0;
         active_ff      <= 1'b0;
         len_pending_ff <= 1'b0;
         words_left_ff  <= '0;
         opcode_ff      <= '0;
         sub_opcode_ff  <= '0;
         position_ff    <= '0;
      end else begin
         hub_mode_ff <= hub_mode_in;
         if (step) begin
            active_ff      <= active_in;
            len_pending_ff <= len_pending_in;
            words_left_ff  <= words_left_in;
            opcode_ff      <= opcode_in;
            sub_opcode_ff  <= sub_opcode_in;
            position_ff    <= position_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         addr_lo_ff <= addr_lo_in;
         addr_hi_ff <= addr_hi_in;
         size_ff    <= size_in;
         id_ff      <= id_in;
      end
   end

   `DPSF_ASSERT(a_ib_on_indirect_end, clock, reset,
      (step && res.ib_valid) |-> (res.packet_end && res.pkt_opcode == OP_INDIRECT),
      "indirect report outside the end of an indirect packet")
   `DPSF_ASSERT(a_header_at_zero, clock, reset,
      (step && !active_ff) |-> (res.is_header && res.word_position == '0),
      "header word not at position zero")
   `DPSF_ASSERT(a_close_expects_header, clock, reset,
      (step && (res.packet_end || res.truncated)) |=> (!active_ff && !len_pending_ff),
      "packet still open after end or truncation")
   `DPSF_ASSERT(a_open_continues, clock, reset,
      (step && !res.packet_end && !last) |=> (active_ff && words_left_ff != '0),
      "packet closed without an end word")
   `DPSF_NEVER(a_end_and_trunc, clock, reset,
      step && res.packet_end && res.truncated,
      "word flagged both packet end and truncated")

endmodule

`default_nettype wire

FILE: hw/rtl/dma_packet_stream_framer.sv
// Path: a word accepted from req goes into the input register, then into the result register,
// which drives rsp_tvalid; the move waits while the result register is full and not taken.
// Throughput: one word per cycle while rsp_tready stays high; the framing state updates
// as a word moves from the input register to the result register.
// Reset: synchronous, active high; clears both valid flags, the packet state
// (next word is a header) and hub_mode. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module dma_packet_stream_framer (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic         csr_wr_data,    // hub_mode
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,      // [31:0] data_word
   input  wire logic         req_tlast,      // stream_last
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [31:0] word_out, [39:32] pkt_opcode, [47:40] pkt_sub_opcode,
   // [79:48] word_position, [80] truncated, [81] ib_valid, [85:82] ib_id,
   // [86] ib_hub, [150:87] ib_address, [182:151] ib_length, [183] zero
   output logic [dpsf_pkg::TDATA_W-1:0] rsp_tdata,
   output logic [0:0]        rsp_tuser,      // [0] is_header
   output logic              rsp_tlast       // packet_end
);
   import dpsf_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic [WORD_W-1:0]   in_word_ff;
   logic                in_last_ff;
   logic                out_valid_ff, out_valid_in;
   dpsf_result_type     out_res_ff;
   dpsf_result_type     core_res;
   logic                advance;

   // move the held word into the result register when that register frees up
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   dpsf_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (advance),
      .word        (in_word_ff),
      .last        (in_last_ff),
      .res         (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_word_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         out_res_ff <= core_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.is_header;
   assign rsp_tlast  = out_res_ff.packet_end;
   assign rsp_tdata  = {1'b0, out_res_ff.ib_length, out_res_ff.ib_address,
                        out_res_ff.ib_hub, out_res_ff.ib_id, out_res_ff.ib_valid,
                        out_res_ff.truncated, out_res_ff.word_position,
                        out_res_ff.pkt_sub_opcode, out_res_ff.pkt_opcode,
                        out_res_ff.word_out};

endmodule

`default_nettype wire

FILE: bench/dpsf_frame_checker.sv
// Framing monitor for dma_packet_stream_framer: tracks packet state from accepted words,
// queues the expected tagging and compares every result transfer. Depends on dpsf_pkg.
`timescale 1ns / 1ps

module dpsf_frame_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic         csr_wr_data,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [31:0]  req_tdata,
   input  wire logic         req_tlast,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [183:0] rsp_tdata,
   input  wire logic [0:0]   rsp_tuser,
   input  wire logic         rsp_tlast,
   output logic              at_header,
   output int                in_flight,
   output int                mismatches,
   output int                n_checked,
   output int                n_ib_reports,
   output int                n_truncated
);
   import dpsf_pkg::*;

   dpsf_result_type tag_q[$];

   logic        hub_bit;
   logic        in_packet;
   logic        count_wait;
   logic [31:0] body_left;
   logic [7:0]  cur_op;
   logic [7:0]  cur_sub;
   logic [31:0] cur_pos;
   logic [31:0] ib_lo;
   logic [31:0] ib_hi;
   logic [31:0] ib_words;
   logic [3:0]  ib_tag;

   assign at_header = !in_packet;

   initial begin
      mismatches   = 0;
      n_checked    = 0;
      n_ib_reports = 0;
      n_truncated  = 0;
      in_flight    = 0;
      in_packet    = 1'b0;
   end

   // payload words after a header; the linear write starts at 3 until its count arrives
   function automatic logic [31:0] body_len(input logic [7:0] op, input logic [7:0] sub,
                                            input logic ext);
      case (op)
         OP_COPY:
            case (sub)
               SUB_COPY_LINEAR: return ext ? 32'd8 : 32'd6;
               SUB_COPY_TILED:  return 32'd11;
               SUB_COPY_L2T:    return 32'd7;
               SUB_COPY_T2T:    return 32'd12;
               SUB_COPY_SOA:    return 32'd13;
               SUB_COPY_DIRTY:  return 32'd14;
               default:         return 32'd0;
            endcase
         OP_WRITE:
            if (sub == SUB_WRITE_LINEAR) return 32'd3;
            else if (sub == SUB_WRITE_TILED) return 32'd9;
            else return 32'd0;
         OP_INDIRECT:    return 32'd5;
         OP_SEMAPHORE:   return 32'd3;
         OP_FENCE:       return 32'd1;
         OP_TRAP:        return 32'd2;
         OP_POLL_REGMEM: return (sub == 8'd0) ? 32'd5 : 32'd3;
         OP_POLL_REG:    return 32'd4;
         OP_COND_EXE:    return 32'd7;
         OP_ATOMIC:      return 32'd4;
         OP_CONST_FILL:  return 32'd9;
         OP_TIMESTAMP:   return (sub <= SUB_TIMESTAMP_MAX) ? 32'd2 : 32'd0;
         OP_SRBM_WRITE:  return 32'd2;
         OP_PRE_EXE:     return 32'd1;
         default:        return 32'd0;
      endcase
   endfunction

   task automatic frame_word(input logic [31:0] w, input logic last,
                             output dpsf_result_type r);
      logic        header;
      logic [31:0] left;
      logic [31:0] total;
      header = !in_packet;
      r = '0;
      if (header) begin
         cur_op     = w[7:0];
         cur_sub    = w[15:8];
         cur_pos    = '0;
         left       = body_len(cur_op, cur_sub, w[COPY_EXT_BIT]);
         count_wait = (cur_op == OP_WRITE) && (cur_sub == SUB_WRITE_LINEAR);
         if (cur_op == OP_INDIRECT) ib_tag = w[ID_LSB +: ID_W];
      end else begin
         if (cur_pos != '1) cur_pos = cur_pos + 1;
         left = body_left - 1;
         if (count_wait && cur_pos == WRITE_COUNT_POS) begin
            // a count that wraps below three ends the packet on this word
            total      = w + 32'd3;
            left       = (total < 32'd3) ? 32'd0 : total - 32'd3;
            count_wait = 1'b0;
         end
         if (cur_op == OP_INDIRECT) begin
            if (cur_pos == IB_ADDR_LO_POS) ib_lo = w;
            else if (cur_pos == IB_ADDR_HI_POS) ib_hi = w;
            else if (cur_pos == IB_SIZE_POS) ib_words = w;
         end
      end
      r.word_out       = w;
      r.is_header      = header;
      r.pkt_opcode     = cur_op;
      r.pkt_sub_opcode = cur_sub;
      r.word_position  = cur_pos;
      if (left == 0) begin
         r.packet_end = 1'b1;
         if (cur_op == OP_INDIRECT) begin
            r.ib_valid   = 1'b1;
            r.ib_id      = ib_tag;
            r.ib_hub     = hub_bit;
            r.ib_address = {ib_hi, ib_lo};
            r.ib_length  = ib_words;
         end
         in_packet  = 1'b0;
         count_wait = 1'b0;
         body_left  = '0;
      end else if (last) begin
         r.truncated = 1'b1;
         in_packet   = 1'b0;
         count_wait  = 1'b0;
         body_left   = '0;
      end else begin
         in_packet = 1'b1;
         body_left = left;
      end
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatches < 20) $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %h want %h", n_checked, name, got, want));
   endtask

   always @(posedge clock) begin
      dpsf_result_type want;
      dpsf_result_type next_tag;
      if (reset) begin
         tag_q.delete();
         hub_bit    = 1'b0;
         in_packet  = 1'b0;
         count_wait = 1'b0;
         body_left  = '0;
         cur_op     = '0;
         cur_sub    = '0;
         cur_pos    = '0;
         ib_lo      = '0;
         ib_hi      = '0;
         ib_words   = '0;
         ib_tag     = '0;
      end else begin
         if (csr_wr_en) hub_bit = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (tag_q.size() == 0) begin
               report_mismatch($sformatf("result word %h with nothing expected",
                                         rsp_tdata[31:0]));
            end else begin
               want = tag_q.pop_front();
               compare_field("word_out", rsp_tdata[31:0], want.word_out);
               compare_field("is_header", rsp_tuser[0], want.is_header);
               compare_field("pkt_opcode", rsp_tdata[39:32], want.pkt_opcode);
               compare_field("pkt_sub_opcode", rsp_tdata[47:40], want.pkt_sub_opcode);
               compare_field("word_position", rsp_tdata[79:48], want.word_position);
               compare_field("packet_end", rsp_tlast, want.packet_end);
               compare_field("truncated", rsp_tdata[80], want.truncated);
               compare_field("ib_valid", rsp_tdata[81], want.ib_valid);
               compare_field("ib_id", rsp_tdata[85:82], want.ib_id);
               compare_field("ib_hub", rsp_tdata[86], want.ib_hub);
               compare_field("ib_address", rsp_tdata[150:87], want.ib_address);
               compare_field("ib_length", rsp_tdata[182:151], want.ib_length);
               n_checked++;
               if (want.ib_valid) n_ib_reports++;
               if (want.truncated) n_truncated++;
            end
         end
         if (req_tvalid && req_tready) begin
            frame_word(req_tdata, req_tlast, next_tag);
            tag_q.push_back(next_tag);
         end
      end
      in_flight <= tag_q.size();
   end

endmodule

FILE: bench/dma_packet_stream_framer_test.sv
// Top of the framer bench: clock, reset, command stream stimulus and verdict.
// Depends on dpsf_pkg, dma_packet_stream_framer and dpsf_frame_checker.
`timescale 1ns / 1ps

module dma_packet_stream_framer_test;
   import dpsf_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic         clock;
   logic         reset;
   logic         csr_wr_en;
   logic         csr_wr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [31:0]  req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [183:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         rsp_tlast;

   logic at_header;
   int   in_flight;
   int   mismatches;
   int   n_checked;
   int   n_ib_reports;
   int   n_truncated;

   logic no_gaps;
   int   words_sent;
   int   cycle_count;

   dma_packet_stream_framer uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   dpsf_frame_checker frame_chk (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .at_header    (at_header),
      .in_flight    (in_flight),
      .mismatches   (mismatches),
      .n_checked    (n_checked),
      .n_ib_reports (n_ib_reports),
      .n_truncated  (n_truncated)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count, in_flight);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side stalls at random unless the steady stretch is on
   always @(negedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(0, 99) >= 12);
   end

   function automatic logic lin_write(input logic [31:0] hdr);
      return hdr[7:0] == OP_WRITE && hdr[15:8] == SUB_WRITE_LINEAR;
   endfunction

   function automatic logic [31:0] pick_header();
      logic [31:0] h;
      int          r;
      h = $urandom();
      r = $urandom_range(0, 99);
      if (r < 10) return h;
      h[15:8] = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 7));
      if (r < 25) begin
         h[7:0] = OP_INDIRECT;
      end else if (r < 40) begin
         h[7:0] = OP_WRITE;
         if (r < 35) h[15:8] = SUB_WRITE_LINEAR;
      end else if (r < 50) begin
         h[7:0] = OP_COPY;
      end else begin
         h[7:0] = 8'($urandom_range(OP_NOP, OP_PRE_EXE));
      end
      return h;
   endfunction

   // enter and leave on a falling edge; hold valid high across back-to-back transfers
   task automatic send_word(input logic [31:0] w, input logic last);
      while (!no_gaps && $urandom_range(0, 99) < 12) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   // header, then payload until the packet closes; cut forces stream end at that position
   task automatic send_packet(input logic [31:0] hdr, input logic [31:0] count, input int cut,
                              input int last_pct);
      int          pos;
      logic [31:0] w;
      pos = 0;
      send_word(hdr, cut == 0 || $urandom_range(0, 99) < last_pct);
      while (!at_header) begin
         pos++;
         w = (lin_write(hdr) && pos == WRITE_COUNT_POS) ? count : $urandom();
         send_word(w, pos == cut || $urandom_range(0, 99) < last_pct);
      end
   endtask

   task automatic send_random(input int words);
      int          stop;
      int          r;
      int          cut;
      logic [31:0] hdr;
      logic [31:0] count;
      stop = words_sent + words;
      while (words_sent < stop) begin
         hdr = pick_header();
         r = $urandom_range(0, 99);
         if (r < 70) count = $urandom_range(0, 12);
         else if (r < 85) count = 32'hFFFF_FFFC + $urandom_range(0, 3);
         else count = $urandom();
         cut = -1;
         if ($urandom_range(0, 99) < 8) cut = $urandom_range(0, 6);
         // bound huge linear writes by ending the stream inside them
         if (lin_write(hdr) && count > 32'd40 && count < 32'hFFFF_FFFD && cut < 0)
            cut = $urandom_range(1, 12);
         send_packet(hdr, count, cut, 3);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (in_flight != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_hub(input logic v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      no_gaps     = 1'b0;
      words_sent  = 0;
      cycle_count = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: hub_mode still at its reset value
      send_packet(32'h0000_0000, '0, -1, 0);
      send_packet(32'hFFFF_FFFF, '0, 0, 0);
      send_packet({16'h0000, 8'h00, OP_FENCE}, '0, 1, 0);
      send_packet({16'h0000, SUB_WRITE_LINEAR, OP_WRITE}, 32'hFFFF_FFFE, -1, 0);
      send_packet({16'hFFFF, SUB_WRITE_LINEAR, OP_WRITE}, 32'hFFFF_FFFC, 4, 0);
      send_packet({16'h0000, SUB_WRITE_LINEAR, OP_WRITE}, '0, 1, 0);
      send_packet({16'h0000, 8'h00, OP_INDIRECT}, '0, 0, 0);
      send_packet({12'h000, 4'hF, 8'h00, OP_INDIRECT}, '0, -1, 0);

      write_hub(1'b1);
      send_random(600);
      write_hub(1'b0);
      no_gaps = 1'b1;
      send_random(400);
      no_gaps = 1'b0;
      write_hub(1'b1);
      send_random(600);
      drain();

      $display("sent %0d stream words, checked %0d results with hub_mode at 0 and 1",
               words_sent, n_checked);
      $display("saw %0d indirect reports and %0d truncated packets", n_ib_reports, n_truncated);
      if (mismatches == 0 && in_flight == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
